[hw/rtl/utp_pkg.sv]
`timescale 1ns / 1ps
// utp_pkg: item types, decoder state and character class functions
// for the UTF-8 text pretokenizer. No dependencies.
package utp_pkg;

    localparam int RES_MAX = 4;
    localparam int CP_W    = 21;

    localparam logic [CP_W-1:0] CP_REPL = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_AE_U = 21'h0000C6;
    localparam logic [CP_W-1:0] CP_AE_L = 21'h0000E6;
    localparam logic [CP_W-1:0] CP_A    = 21'h000061;
    localparam logic [CP_W-1:0] CP_E    = 21'h000065;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            token_last;
        logic            text_last;
        logic            no_char;
    } out_t;

    typedef struct packed {
        logic [2:0][7:0] held;
        logic [1:0]      hcnt;
        logic [1:0]      need;
        logic [CP_W-1:0] pchar;
        logic            pvalid;
        logic            psolo;
    } state_t;

    function automatic logic is_ctrl(input logic [CP_W-1:0] c);
        if (c == 21'd9 || c == 21'd10 || c == 21'd13)
            return 1'b0;
        return (c < 21'd32) || (c >= 21'h7F && c <= 21'h9F);
    endfunction

    function automatic logic is_space(input logic [CP_W-1:0] c);
        return c == 21'd32 || c == 21'd9 || c == 21'd10 || c == 21'd13 ||
               c == 21'hA0 || c == 21'h1680 || (c >= 21'h2000 && c <= 21'h200A) ||
               c == 21'h2028 || c == 21'h2029 || c == 21'h202F ||
               c == 21'h205F || c == 21'h3000;
    endfunction

    function automatic logic is_punct(input logic [CP_W-1:0] c);
        return (c >= 21'd33 && c <= 21'd47) || (c >= 21'd58 && c <= 21'd64) ||
               (c >= 21'd91 && c <= 21'd96) || (c >= 21'd123 && c <= 21'd126) ||
               (c >= 21'hA1 && c <= 21'hBF) || (c >= 21'h2010 && c <= 21'h2027) ||
               (c >= 21'h2030 && c <= 21'h205E) || (c >= 21'h3001 && c <= 21'h303F) ||
               c == 21'h058A || c == 21'h05BE || c == 21'h055A || c == 21'h055B;
    endfunction

    function automatic logic is_han(input logic [CP_W-1:0] c);
        return (c >= 21'h4E00 && c <= 21'h9FFF) || (c >= 21'h3400 && c <= 21'h4DBF) ||
               (c >= 21'h20000 && c <= 21'h2A6DF) || (c >= 21'h2A700 && c <= 21'h2CEAF) ||
               (c >= 21'hF900 && c <= 21'hFAFF) || (c >= 21'h2F800 && c <= 21'h2FA1F);
    endfunction

    function automatic logic is_mark(input logic [CP_W-1:0] c);
        return (c >= 21'h0300 && c <= 21'h036F) || (c >= 21'h1AB0 && c <= 21'h1AFF) ||
               (c >= 21'h1DC0 && c <= 21'h1DFF) || (c >= 21'h20D0 && c <= 21'h20FF) ||
               (c >= 21'hFE20 && c <= 21'hFE2F);
    endfunction

    // lower-case base letter; 0 means keep the code point
    function automatic logic [7:0] fold_map(input logic [CP_W-1:0] c);
        logic [7:0] m;
        logic [4:0] i1;
        logic [6:0] i2;
        m  = 8'd0;
        i1 = c[4:0];
        i2 = c[6:0];
        if (c >= 21'hC0 && c <= 21'hFF) begin
            case (i1) inside
                [5'd0:5'd5]:   m = "a";
                5'd7:          m = "c";
                [5'd8:5'd11]:  m = "e";
                [5'd12:5'd15]: m = "i";
                5'd16:         m = "d";
                5'd17:         m = "n";
                [5'd18:5'd22]: m = "o";
                5'd24:         m = "o";
                [5'd25:5'd28]: m = "u";
                5'd29:         m = "y";
                5'd31:         m = c[5] ? "y" : "s";
                default:       m = 8'd0;
            endcase
        end
        else if (c >= 21'h100 && c <= 21'h17F) begin
            case (i2) inside
                [7'd0:7'd5]:     m = "a";
                [7'd6:7'd13]:    m = "c";
                [7'd14:7'd17]:   m = "d";
                [7'd18:7'd27]:   m = "e";
                [7'd28:7'd35]:   m = "g";
                [7'd36:7'd39]:   m = "h";
                [7'd40:7'd49]:   m = "i";
                [7'd52:7'd53]:   m = "j";
                [7'd54:7'd55]:   m = "k";
                [7'd57:7'd66]:   m = "l";
                [7'd67:7'd72]:   m = "n";
                [7'd76:7'd81]:   m = "o";
                [7'd84:7'd89]:   m = "r";
                [7'd90:7'd97]:   m = "s";
                [7'd98:7'd103]:  m = "t";
                [7'd104:7'd115]: m = "u";
                [7'd116:7'd117]: m = "w";
                [7'd118:7'd120]: m = "y";
                [7'd121:7'd126]: m = "z";
                default:         m = 8'd0;
            endcase
        end
        return m;
    endfunction

    function automatic logic [CP_W-1:0] fold_letter(input logic [CP_W-1:0] c);
        logic [7:0] m;
        m = fold_map(c);
        if (c >= 21'd65 && c <= 21'd90)
            return c + 21'd32;
        if (m != 8'd0)
            return {13'd0, m};
        return c;
    endfunction

endpackage

[hw/rtl/utf8_text_pretokenizer.sv]
`timescale 1ns / 1ps
// utf8_text_pretokenizer: streaming UTF-8 pretokenizer top level.
// The first result item is registered and offered in the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte yields at most one result and the output is not stalled;
// a byte yielding several results holds the input until the result buffer drains to its last item.
// Reset: rst_n asynchronous, active low; clears decoder state and result count.
module utf8_text_pretokenizer
    import utp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_item,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_item
);

    state_t             st_reg;
    state_t             st_next;
    out_t [RES_MAX-1:0] res_reg;
    out_t [RES_MAX-1:0] res_next;
    logic [2:0]         cnt_reg;
    logic [2:0]         cnt_next;
    logic [1:0]         rd_reg;
    logic               in_fire;
    logic               out_fire;

    utp_step u_step (
        .st      (st_reg),
        .item    (in_item),
        .st_next (st_next),
        .res     (res_next),
        .res_cnt (cnt_next)
    );

    assign out_valid = cnt_reg != 3'd0;
    assign out_item  = res_reg[rd_reg];
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && out_ready);
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= '0;
            cnt_reg <= 3'd0;
            rd_reg  <= 2'd0;
        end
        else if (in_fire)
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            rd_reg  <= 2'd0;
        end
        else if (out_fire)
        begin
            cnt_reg <= cnt_reg - 3'd1;
            rd_reg  <= rd_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            res_reg <= res_next;
    end

endmodule

[hw/rtl/utp_step.sv]
`timescale 1ns / 1ps
// utp_step: one byte of work: UTF-8 assembly, normalisation and token
// boundaries, giving up to four result items. Depends on utp_pkg.
module utp_step
    import utp_pkg::*;
(
    input  state_t                st,
    input  in_t                   item,
    output state_t                st_next,
    output out_t [RES_MAX-1:0]    res,
    output logic [2:0]            res_cnt
);

    logic [7:0]      b [4];
    logic [2:0]      len;
    logic [2:0]      pos;
    logic [2:0]      avail;
    logic [7:0]      c0;
    logic [7:0]      c1;
    logic [7:0]      c2;
    logic [7:0]      c3;
    logic            run;
    logic            lead2;
    logic            lead3;
    logic            lead4;
    logic [CP_W-1:0] ch  [4];
    logic            chv [4];
    logic [CP_W-1:0] acc_c [2];
    logic            acc_v [2];
    logic            acc_s [2];
    logic [CP_W-1:0] cf;
    logic [CP_W-1:0] pc;
    logic            pv;
    logic            ps;
    logic [2:0]      n;

    assign lead2 = item.text_byte[7:5] == 3'b110;
    assign lead3 = item.text_byte[7:4] == 4'b1110;
    assign lead4 = item.text_byte[7:3] == 5'b11110;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            b[i] = st.held[i];
        end
        b[3] = 8'd0;
        b[st.hcnt] = item.text_byte;
        len = {1'b0, st.hcnt} + 3'd1;

        run = item.last_byte ||
              (st.hcnt == 2'd0 && !(lead2 || lead3 || lead4)) ||
              (st.hcnt != 2'd0 && (len >= {1'b0, st.need} + 3'd1 || len == 3'd4));

        // byte run decode, end of run known
        pos = 3'd0;
        for (int s = 0; s < 4; s++)
        begin
            ch[s]  = '0;
            chv[s] = 1'b0;
            avail  = len - pos;
            c0 = b[pos[1:0]];
            c1 = b[2'(pos + 3'd1)];
            c2 = b[2'(pos + 3'd2)];
            c3 = b[2'(pos + 3'd3)];
            if (run && pos < len)
            begin
                chv[s] = 1'b1;
                if (!c0[7])
                begin
                    ch[s] = {13'd0, c0};
                    pos   = pos + 3'd1;
                end
                else if (c0[7:5] == 3'b110 && avail >= 3'd2)
                begin
                    ch[s] = {10'd0, c0[4:0], c1[5:0]};
                    pos   = pos + 3'd2;
                end
                else if (c0[7:4] == 4'b1110 && avail >= 3'd3)
                begin
                    ch[s] = {5'd0, c0[3:0], c1[5:0], c2[5:0]};
                    pos   = pos + 3'd3;
                end
                else if (c0[7:3] == 5'b11110 && avail >= 3'd4)
                begin
                    ch[s] = {c0[2:0], c1[5:0], c2[5:0], c3[5:0]};
                    pos   = pos + 3'd4;
                end
                else
                begin
                    ch[s] = CP_REPL;
                    pos   = pos + 3'd1;
                end
            end
        end

        pc = st.pchar;
        pv = st.pvalid;
        ps = st.psolo;
        n  = 3'd0;
        for (int k = 0; k < RES_MAX; k++)
        begin
            res[k] = '0;
        end

        for (int s = 0; s < 4; s++)
        begin
            acc_c[0] = '0;
            acc_c[1] = '0;
            acc_v[0] = 1'b0;
            acc_v[1] = 1'b0;
            acc_s[0] = 1'b0;
            acc_s[1] = 1'b0;
            cf = fold_letter(ch[s]);
            if (chv[s] && ch[s] != '0 && !is_ctrl(ch[s]) && !is_mark(ch[s]))
            begin
                if (is_space(ch[s]))
                begin
                    if (pv)
                        ps = 1'b1;
                end
                else if (is_han(ch[s]))
                begin
                    acc_c[0] = ch[s];
                    acc_v[0] = 1'b1;
                    acc_s[0] = 1'b1;
                end
                else if (ch[s] == CP_AE_U || ch[s] == CP_AE_L)
                begin
                    acc_c[0] = CP_A;
                    acc_v[0] = 1'b1;
                    acc_c[1] = CP_E;
                    acc_v[1] = 1'b1;
                end
                else
                begin
                    acc_c[0] = cf;
                    acc_v[0] = 1'b1;
                    acc_s[0] = is_punct(cf);
                end
            end
            for (int k = 0; k < 2; k++)
            begin
                if (acc_v[k])
                begin
                    if (pv && n < 3'd4)
                    begin
                        res[n[1:0]] = '{code_point: pc, token_last: ps | acc_s[k],
                                        text_last: 1'b0, no_char: 1'b0};
                        n = n + 3'd1;
                    end
                    pc = acc_c[k];
                    ps = acc_s[k];
                    pv = 1'b1;
                end
            end
        end

        st_next = st;
        if (item.last_byte)
        begin
            if (n < 3'd4)
            begin
                if (pv)
                    res[n[1:0]] = '{code_point: pc, token_last: 1'b1,
                                    text_last: 1'b1, no_char: 1'b0};
                else
                    res[n[1:0]] = '{code_point: '0, token_last: 1'b0,
                                    text_last: 1'b1, no_char: 1'b1};
                n = n + 3'd1;
            end
            st_next = '0;
        end
        else
        begin
            st_next.pchar  = pc;
            st_next.pvalid = pv;
            st_next.psolo  = ps;
            if (run)
            begin
                st_next.held = '0;
                st_next.hcnt = 2'd0;
                st_next.need = 2'd0;
            end
            else if (st.hcnt == 2'd0)
            begin
                st_next.held[0] = item.text_byte;
                st_next.hcnt    = 2'd1;
                st_next.need    = lead2 ? 2'd1 : (lead3 ? 2'd2 : 2'd3);
            end
            else
            begin
                st_next.held[st.hcnt] = item.text_byte;
                st_next.hcnt          = st.hcnt + 2'd1;
            end
        end
        res_cnt = n;
    end

endmodule

[sim/utf8_text_pretokenizer_tb.sv]
`timescale 1ns / 1ps
// utf8_text_pretokenizer_tb: byte streams in, normalised characters checked
// against an in-bench model of the pretokenizer. Depends on utp_pkg and the RTL.
module utf8_text_pretokenizer_tb;
    import utp_pkg::*;

    class char_board;
        logic [7:0]      held [3];
        int              hcnt;
        int              need;
        logic [CP_W-1:0] pchar;
        bit              pvalid;
        bit              psolo;
        out_t            wanted [$];
        int              errors;

        function void clear();
            held[0] = 0; held[1] = 0; held[2] = 0;
            hcnt = 0; need = 0; pchar = 0; pvalid = 0; psolo = 0;
        endfunction

        function void push(logic [CP_W-1:0] cp, bit tok, bit txt, bit none);
            out_t r;
            r.code_point = cp;
            r.token_last = tok;
            r.text_last  = txt;
            r.no_char    = none;
            wanted = {wanted, r};
        endfunction

        static function bit ctrl_c(int unsigned c);
            if (c == 9 || c == 10 || c == 13)
                return 0;
            return c < 32 || (c >= 'h7F && c <= 'h9F);
        endfunction

        static function bit space_c(int unsigned c);
            return c == 32 || c == 9 || c == 10 || c == 13 || c == 'hA0 || c == 'h1680
                || (c >= 'h2000 && c <= 'h200A) || c == 'h2028 || c == 'h2029
                || c == 'h202F || c == 'h205F || c == 'h3000;
        endfunction

        static function bit punct_c(int unsigned c);
            return (c >= 33 && c <= 47) || (c >= 58 && c <= 64) || (c >= 91 && c <= 96)
                || (c >= 123 && c <= 126) || (c >= 'hA1 && c <= 'hBF)
                || (c >= 'h2010 && c <= 'h2027) || (c >= 'h2030 && c <= 'h205E)
                || (c >= 'h3001 && c <= 'h303F) || c == 'h58A || c == 'h5BE
                || c == 'h55A || c == 'h55B;
        endfunction

        static function bit han_c(int unsigned c);
            return (c >= 'h4E00 && c <= 'h9FFF) || (c >= 'h3400 && c <= 'h4DBF)
                || (c >= 'h20000 && c <= 'h2A6DF) || (c >= 'h2A700 && c <= 'h2CEAF)
                || (c >= 'hF900 && c <= 'hFAFF) || (c >= 'h2F800 && c <= 'h2FA1F);
        endfunction

        static function bit mark_c(int unsigned c);
            return (c >= 'h300 && c <= 'h36F) || (c >= 'h1AB0 && c <= 'h1AFF)
                || (c >= 'h1DC0 && c <= 'h1DFF) || (c >= 'h20D0 && c <= 'h20FF)
                || (c >= 'hFE20 && c <= 'hFE2F);
        endfunction

        static function int unsigned lower_base(int unsigned c);
            string t1;
            string t2;
            byte   m;
            t1 = {"aaaaaa.ceeeeiiiidnooooo.ouuuuy.s", "aaaaaa.ceeeeiiiidnooooo.ouuuuy.y"};
            t2 = {"aaaaaaccccccccddddeeeeeeeeeegggggggghhhhiiiiiiiiii..jjkk.",
                  "llllllllllnnnnnn...oooooo..rrrrrrssssssssttttttuuuuuuuuuuuu",
                  "wwyyyzzzzzz."};
            m = ".";
            if (c >= 65 && c <= 90)
                return c + 32;
            if (c >= 'hC0 && c <= 'hFF)
                m = t1[c - 'hC0];
            else if (c >= 'h100 && c <= 'h17F)
                m = t2[c - 'h100];
            return (m == ".") ? c : m;
        endfunction

        function void take(int unsigned c, bit solo);
            if (pvalid)
                push(pchar, psolo || solo, 0, 0);
            pchar = c; psolo = solo; pvalid = 1;
        endfunction

        function void feed(int unsigned c);
            if (c == 0 || ctrl_c(c) || mark_c(c))
                return;
            if (space_c(c)) begin
                if (pvalid)
                    psolo = 1;
                return;
            end
            if (han_c(c)) begin
                take(c, 1);
                return;
            end
            if (c == CP_AE_U || c == CP_AE_L) begin
                take(CP_A, 0);
                take(CP_E, 0);
                return;
            end
            c = lower_base(c);
            take(c, punct_c(c));
        endfunction

        function void decode_run(logic [7:0] b [4], int len);
            int          i;
            int unsigned c;
            int unsigned cp;
            int          adv;
            i = 0;
            while (i < len) begin
                c = b[i];
                adv = 1;
                if (c < 'h80)
                    cp = c;
                else if ((c >> 5) == 6 && i + 1 < len) begin
                    cp = ((c & 'h1F) << 6) | (b[i+1] & 'h3F);
                    adv = 2;
                end
                else if ((c >> 4) == 'hE && i + 2 < len) begin
                    cp = ((c & 'hF) << 12) | ((b[i+1] & 'h3F) << 6) | (b[i+2] & 'h3F);
                    adv = 3;
                end
                else if ((c >> 3) == 'h1E && i + 3 < len) begin
                    cp = ((c & 7) << 18) | ((b[i+1] & 'h3F) << 12)
                       | ((b[i+2] & 'h3F) << 6) | (b[i+3] & 'h3F);
                    adv = 4;
                end
                else
                    cp = CP_REPL;
                feed(cp);
                i += adv;
            end
        endfunction

        function void note_byte(in_t it);
            logic [7:0] buf4 [4];
            int         len;
            len = 0;
            for (int i = 0; i < hcnt; i++) begin
                buf4[len] = held[i];
                len++;
            end
            buf4[len] = it.text_byte;
            len++;
            if (it.last_byte) begin
                decode_run(buf4, len);
                if (pvalid)
                    push(pchar, 1, 1, 0);
                else
                    push(0, 0, 1, 1);
                clear();
            end
            else if (len == 1) begin
                if (it.text_byte[7:5] == 3'b110)
                    need = 1;
                else if (it.text_byte[7:4] == 4'hE)
                    need = 2;
                else if (it.text_byte[7:3] == 5'h1E)
                    need = 3;
                else begin
                    decode_run(buf4, 1);
                    return;
                end
                held[0] = it.text_byte;
                hcnt = 1;
            end
            else if (len >= need + 1 || len >= 4) begin
                decode_run(buf4, len);
                held[0] = 0; held[1] = 0; held[2] = 0;
                hcnt = 0; need = 0;
            end
            else begin
                held[len-1] = it.text_byte;
                hcnt = len;
            end
        endfunction

        function void check_char(out_t got);
            out_t w;
            if (wanted.size() == 0) begin
                $error("unexpected item %h", got);
                errors++;
                return;
            end
            w = wanted.pop_front();
            if (got.code_point !== w.code_point) begin
                $error("code_point exp %h got %h", w.code_point, got.code_point);
                errors++;
            end
            if (got.token_last !== w.token_last) begin
                $error("token_last exp %b got %b", w.token_last, got.token_last);
                errors++;
            end
            if (got.text_last !== w.text_last) begin
                $error("text_last exp %b got %b", w.text_last, got.text_last);
                errors++;
            end
            if (got.no_char !== w.no_char) begin
                $error("no_char exp %b got %b", w.no_char, got.no_char);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_item;
    logic out_valid;
    logic out_ready;
    out_t out_item;

    char_board board;
    int        src_idle;
    int        dst_idle;
    longint    cycles;

    utf8_text_pretokenizer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 200000) begin
                $display("utf8_text_pretokenizer_tb: done, errors");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_char(out_item);
        out_ready <= ($urandom_range(99) >= dst_idle);
    end

    // valid is dropped only for idle cycles, so each edge sees one update
    task automatic send_byte(logic [7:0] b, bit last);
        if ($urandom_range(99) < src_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle)
                @(posedge clk);
        end
        in_valid <= 1;
        in_item  <= '{text_byte: b, last_byte: last};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_byte('{text_byte: b, last_byte: last});
    endtask

    task automatic send_text(logic [7:0] s [$]);
        foreach (s[i])
            send_byte(s[i], i == s.size() - 1);
    endtask

    // characters from varied classes (four-byte ones with a random second byte), with noise now and then
    task automatic random_text(ref int sent);
        logic [7:0]  s [$];
        int          n;
        int unsigned c;
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            case ($urandom_range(9))
                0:       c = $urandom_range('h7F);
                1:       c = $urandom_range('h80, 'h7FF);
                2:       c = $urandom_range('h100, 'h17F);
                3:       c = $urandom_range('h2000, 'h3040);
                4:       c = $urandom_range('h4E00, 'h9FFF);
                5:       c = $urandom_range('h800, 'hFFFF);
                6:       c = $urandom_range('h10000, 'h1FFFFF);
                7:       c = $urandom_range('h300, 'h36F);
                default: c = $urandom_range(32, 126);
            endcase
            if ($urandom_range(9) == 0)
                s = {s, 8'($urandom_range(255))};
            else if (c < 'h80)
                s = {s, 8'(c)};
            else if (c < 'h800) begin
                s = {s, 8'('hC0 | (c >> 6))};
                s = {s, 8'('h80 | (c & 'h3F))};
            end
            else if (c < 'h10000) begin
                s = {s, 8'('hE0 | (c >> 12))};
                s = {s, 8'('h80 | ((c >> 6) & 'h3F))};
                s = {s, 8'('h80 | (c & 'h3F))};
            end
            else begin
                s = {s, 8'('hF0 | (c >> 18))};
                s = {s, 8'($urandom_range(255))};
                s = {s, 8'('h80 | ((c >> 6) & 'h3F))};
                s = {s, 8'('h80 | (c & 'h3F))};
            end
        end
        if ($urandom_range(7) == 0 && s.size() != 0)
            s = s[0:$-1];
        if (s.size() == 0)
            s = {s, 8'($urandom_range(255))};
        send_text(s);
        sent += s.size();
    endtask

    initial
    begin
        int sent;
        int limit;
        board = new();
        board.clear();
        board.errors = 0;
        rst_n = 0;
        in_valid = 0;
        in_item = '0;
        out_ready = 0;
        src_idle = 30;
        dst_idle = 71;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_text('{8'h00});
        send_text('{8'h41, 8'h20, 8'hC3, 8'h86, 8'h2C, 8'hFF});
        send_text('{8'hE4, 8'hB8, 8'h80, 8'h61, 8'hCC, 8'h81, 8'h09});
        send_text('{8'hF0, 8'hA0, 8'h80, 8'h80, 8'h80, 8'hE2});
        send_text('{8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h7F, 8'h5A, 8'hE2, 8'h80});
        send_text('{8'hC4, 8'h80, 8'hC5, 8'hBF, 8'hE3, 8'h80, 8'h80, 8'hF8});

        sent = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle = (ph == 0) ? 30 : (ph == 1) ? 71 : 0;
            dst_idle = (ph == 0) ? 71 : (ph == 1) ? 30 : 0;
            while (sent < 75 * (ph + 1))
                random_text(sent);
        end
        in_valid <= 0;

        limit = 0;
        while (board.wanted.size() != 0 && limit < 20000)
        begin
            @(posedge clk);
            limit++;
        end
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.wanted.size() == 0)
            $display("utf8_text_pretokenizer_tb: done, clean");
        else
            $display("utf8_text_pretokenizer_tb: done, errors");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/utp_pkg.sv
hw/rtl/utp_step.sv
hw/rtl/utf8_text_pretokenizer.sv
sim/utf8_text_pretokenizer_tb.sv
